FILE: rtl/core/knn_pkg.sv
// knn_pkg: shared types and constants of the brute-force l2 k-nearest-neighbor block
// no dependencies
package knn_pkg;
   localparam int MaxPoints = 1024;
   localparam int MaxDim = 64;
   localparam int MaxK = 16;
   localparam int CoordBits = 16;
   localparam int StoreDepth = MaxPoints * MaxDim;
   localparam int AddrBits = $clog2(StoreDepth);
   localparam int PtBits = $clog2(MaxPoints);
   localparam int DimBits = $clog2(MaxDim + 1);
   localparam int KBits = $clog2(MaxK);
   localparam int DistBits = 39;
   localparam int SqBits = 2 * CoordBits + 1;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_BAD_K = 2'd1;
   localparam logic [1:0] STATUS_BAD_QUERY = 2'd2;

   localparam logic [1:0] CSR_K = 2'd0;
   localparam logic [1:0] CSR_POINTS = 2'd1;
   localparam logic [1:0] CSR_DIMS = 2'd2;

   typedef struct packed {
      logic clear;
      logic load;
      logic rd_issue;
      logic acc_first;
      logic acc_en;
      logic insert;
      logic [PtBits-1:0] row;
      logic [DimBits-1:0] dim;
      logic [KBits-1:0] out_slot;
   } cmd_type;

   typedef struct packed {
      logic [AddrBits-1:0] load_ptr;
   } status_type;
endpackage

FILE: rtl/core/knn_ram.sv
// knn_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
module knn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: rtl/core/knn_datapath.sv
// knn_datapath: point store, load pointer, distance accumulator and sorted best list
// depends on knn_pkg and knn_ram
module knn_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  knn_pkg::cmd_type             cmd,
   input  logic [knn_pkg::CoordBits-1:0] load_coord,
   input  logic [knn_pkg::PtBits-1:0]   query_pt,
   input  logic [knn_pkg::DimBits-1:0]  eff_dims,
   input  logic [knn_pkg::AddrBits:0]   limit,
   input  logic [knn_pkg::KBits-1:0]    k_last,
   output knn_pkg::status_type          status,
   output logic [knn_pkg::PtBits-1:0]   out_index,
   output logic [knn_pkg::DistBits-1:0] out_dist
);
   import knn_pkg::*;

   logic [AddrBits-1:0] ptr_ff, ptr_in, wr_addr, q_addr, r_addr, rd_addr;
   logic [CoordBits-1:0] rd_data;
   logic [CoordBits-1:0] x_ff, x_in;
   logic sel_q_ff, sel_r_ff;
   logic [SqBits-1:0] sq_ff, sq_in;
   logic acc_first_ff, acc_v_ff, acc_first2_ff;
   logic [DistBits-1:0] acc_ff, acc_in;
   logic [DistBits-1:0] bd_ff [MaxK];
   logic [DistBits-1:0] bd_in [MaxK];
   logic [PtBits-1:0] bi_ff [MaxK];
   logic [PtBits-1:0] bi_in [MaxK];
   logic [PtBits-1:0] row_ff, row2_ff;
   logic signed [CoordBits:0] diff;
   logic [MaxK-1:0] gt;

   // load pointer with wrap
   always_comb begin
      wr_addr = ({1'b0, ptr_ff} >= limit) ? '0 : ptr_ff;
      ptr_in = ptr_ff;
      if (cmd.load) begin
         ptr_in = (({1'b0, wr_addr} + 1'b1) >= limit) ? '0 : wr_addr + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
      end
   end

   assign status.load_ptr = ptr_ff;

   // alternate reads: query coordinate then row coordinate
   assign q_addr = AddrBits'(query_pt * eff_dims + cmd.dim);
   assign r_addr = AddrBits'(cmd.row * eff_dims + cmd.dim);
   assign rd_addr = cmd.acc_en ? r_addr : q_addr;

   knn_ram #(.WIDTH(CoordBits), .DEPTH(StoreDepth)) u_store (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (wr_addr),
      .wr_data (load_coord),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign diff = $signed({x_ff[CoordBits-1], x_ff}) - $signed({rd_data[CoordBits-1], rd_data});
   assign x_in = sel_q_ff ? rd_data : x_ff;
   assign sq_in = SqBits'($unsigned((SqBits+1)'(diff) * (SqBits+1)'(diff)));
   assign acc_in = acc_first2_ff ? DistBits'(sq_ff) : acc_ff + DistBits'(sq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_q_ff <= 1'b0;
         sel_r_ff <= 1'b0;
         acc_v_ff <= 1'b0;
      end else begin
         sel_q_ff <= cmd.rd_issue;
         sel_r_ff <= cmd.acc_en;
         acc_v_ff <= sel_r_ff;
      end
      x_ff <= x_in;
      sq_ff <= sq_in;
      acc_first_ff <= cmd.acc_first;
      acc_first2_ff <= acc_first_ff;
      row_ff <= cmd.row;
      row2_ff <= row_ff;
      if (acc_v_ff) begin
         acc_ff <= acc_in;
      end
   end

   // sorted insert, ties keep the earlier (lower) index
   always_comb begin
      for (int j = 0; j < MaxK; j++) begin
         gt[j] = bd_ff[j] > acc_ff;
      end
      for (int j = 0; j < MaxK; j++) begin
         bd_in[j] = bd_ff[j];
         bi_in[j] = bi_ff[j];
         if (cmd.clear) begin
            bd_in[j] = '1;
            bi_in[j] = '0;
         end else if (cmd.insert && gt[k_last] && (j <= int'(k_last)) && gt[j]) begin
            if (j == 0 || !gt[j-1]) begin
               bd_in[j] = acc_ff;
               bi_in[j] = row2_ff;
            end else begin
               bd_in[j] = bd_ff[j-1];
               bi_in[j] = bi_ff[j-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < MaxK; j++) begin
         bd_ff[j] <= bd_in[j];
         bi_ff[j] <= bi_in[j];
      end
   end

   assign out_index = bi_ff[cmd.out_slot];
   assign out_dist = bd_ff[cmd.out_slot];
endmodule

FILE: rtl/core/knn_ctrl.sv
// knn_ctrl: controller that sequences loads, the distance sweep and result emission
// depends on knn_pkg
module knn_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic                        req_func,
   input  logic [knn_pkg::PtBits-1:0]  req_query,
   input  logic [4:0]                  k_cfg,
   input  logic [10:0]                 n_eff,
   input  logic [knn_pkg::DimBits-1:0] eff_dims,
   output knn_pkg::cmd_type            cmd,
   output logic [knn_pkg::PtBits-1:0]  query_ff_o,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [1:0]                  out_status,
   output logic [knn_pkg::KBits-1:0]   out_rank,
   output logic                        out_last
);
   import knn_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_RDQ  = 5'b00010,
      S_RDR  = 5'b00100,
      S_DRAIN = 5'b01000,
      S_EMIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [PtBits-1:0] q_ff, q_in;
   logic [10:0] row_ff, row_in;
   logic [DimBits-1:0] dim_ff, dim_in;
   logic [2:0] drain_ff, drain_in;
   logic [KBits-1:0] slot_ff, slot_in;
   logic [1:0] stat_ff, stat_in;
   logic take;
   logic k_bad;
   logic [10:0] skip_row;

   assign k_bad = (k_cfg == '0) || (k_cfg > 5'(MaxK)) || ({6'd0, k_cfg} + 11'd1 > n_eff);
   assign req_tready = (state_ff == S_IDLE);
   assign take = req_tvalid && req_tready;
   assign skip_row = (row_ff == {1'b0, q_ff}) ? row_ff + 11'd1 : row_ff;

   always_comb begin
      state_in = state_ff;
      q_in = q_ff;
      row_in = row_ff;
      dim_in = dim_ff;
      drain_in = drain_ff;
      slot_in = slot_ff;
      stat_in = stat_ff;
      cmd = '0;
      cmd.load = take && !req_func;
      cmd.row = skip_row[PtBits-1:0];
      cmd.dim = dim_ff;
      cmd.out_slot = slot_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (take && req_func) begin
               q_in = req_query;
               slot_in = '0;
               if (k_bad) begin
                  stat_in = STATUS_BAD_K;
                  state_in = S_EMIT;
               end else if ({1'b0, req_query} >= n_eff) begin
                  stat_in = STATUS_BAD_QUERY;
                  state_in = S_EMIT;
               end else begin
                  stat_in = STATUS_OK;
                  cmd.clear = 1'b1;
                  row_in = (req_query == '0) ? 11'd1 : 11'd0;
                  dim_in = '0;
                  state_in = S_RDQ;
               end
            end
         end
         S_RDQ: begin
            cmd.rd_issue = 1'b1;
            state_in = S_RDR;
         end
         S_RDR: begin
            cmd.acc_en = 1'b1;
            cmd.acc_first = (dim_ff == '0);
            if (dim_ff + 1'b1 == eff_dims) begin
               dim_in = '0;
               drain_in = 3'd4;
               state_in = S_DRAIN;
            end else begin
               dim_in = dim_ff + 1'b1;
               state_in = S_RDQ;
            end
         end
         S_DRAIN: begin
            drain_in = drain_ff - 1'b1;
            if (drain_ff == 3'd1) begin
               cmd.insert = 1'b1;
               row_in = skip_row + 11'd1;
               if (row_in == {1'b0, q_ff}) begin
                  row_in = row_in + 11'd1;
               end
               state_in = (row_in >= n_eff) ? S_EMIT : S_RDQ;
            end
         end
         S_EMIT: begin
            if (out_ready) begin
               if (out_last) begin
                  state_in = S_IDLE;
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      q_ff <= q_in;
      row_ff <= row_in;
      dim_ff <= dim_in;
      drain_ff <= drain_in;
      slot_ff <= slot_in;
      stat_ff <= stat_in;
   end

   assign query_ff_o = q_ff;
   assign out_valid = (state_ff == S_EMIT);
   assign out_status = stat_ff;
   assign out_rank = slot_ff;
   assign out_last = (stat_ff != STATUS_OK) || ({1'b0, slot_ff} + 1'b1 == k_cfg);
endmodule

FILE: rtl/core/knn_graph_l2_brute_force.sv
// knn_graph_l2_brute_force: top level of the brute-force l2 k-nearest-neighbor block
// depends on knn_pkg, knn_ctrl, knn_datapath, knn_ram
//
// channel  dir  fields (low bit first)
// req      in   tuser: func; tdata: coord[15:0], query[25:16]
// rsp      out  tdata: query_echo, rank, neighbor, distance, status; tlast: last
// csr      in   index 0 k_neighbors, 1 num_points, 2 dims
//
// a load is written to the point store as it is accepted; a valid query sweeps every row
// but the query point, reading query and row coordinate alternately through the single
// read port of the point store and draining the pipeline after each row, then emits the
// results in rank order; req_tready is low from query accept to the last rsp transfer
// the point store is not cleared by reset; unwritten entries read undefined
module knn_graph_l2_brute_force (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // coord[15:0], query[25:16]
   input  logic        req_tuser,  // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // query_echo, rank, neighbor, distance, status
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata
);
   import knn_pkg::*;

   logic [4:0] k_ff;
   logic [10:0] n_ff, n_eff;
   logic [6:0] d_ff;
   logic [DimBits-1:0] d_eff;
   logic [AddrBits:0] limit;
   cmd_type cmd;
   status_type stat;
   logic [PtBits-1:0] q;
   logic [PtBits-1:0] nb;
   logic [DistBits-1:0] nb_dist;
   logic [1:0] st;
   logic [KBits-1:0] rank;
   logic [KBits-1:0] k_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= 5'd1;
         n_ff <= 11'd2;
         d_ff <= 7'd1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_K: k_ff <= csr_wdata[4:0];
            CSR_POINTS: n_ff <= csr_wdata;
            CSR_DIMS: d_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   assign n_eff = (n_ff > 11'(MaxPoints)) ? 11'(MaxPoints) : n_ff;
   assign d_eff = (d_ff == '0) ? DimBits'(1) : (d_ff > 7'(MaxDim)) ? DimBits'(MaxDim) : d_ff;
   assign limit = (AddrBits+1)'(n_eff * d_eff);
   assign k_last = KBits'(k_ff - 5'd1);

   knn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .req_query  (req_tdata[25:16]),
      .k_cfg      (k_ff),
      .n_eff      (n_eff),
      .eff_dims   (d_eff),
      .cmd        (cmd),
      .query_ff_o (q),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_status (st),
      .out_rank   (rank),
      .out_last   (rsp_tlast)
   );

   knn_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .load_coord (req_tdata[15:0]),
      .query_pt   (q),
      .eff_dims   (d_eff),
      .limit      (limit),
      .k_last     (k_last),
      .status     (stat),
      .out_index  (nb),
      .out_dist   (nb_dist)
   );

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[9:0] = q;
      if (st == STATUS_OK) begin
         rsp_tdata[13:10] = rank;
         rsp_tdata[23:14] = nb;
         rsp_tdata[62:24] = nb_dist;
      end
      rsp_tdata[64:63] = st;
   end

`ifndef NO_ASSERTIONS
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !req_tuser)
      |=> ({1'b0, stat.load_ptr} < limit || $past(csr_wr_en)))
      else $error("load pointer out of range");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while results pending");
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[64:63] != STATUS_OK) |-> rsp_tlast)
      else $error("error result not last");
`endif
endmodule

FILE: tb/sv/knn_graph_l2_brute_force_tb.sv
// testbench for knn_graph_l2_brute_force: loads datasets, issues neighbor queries and
// checks every response transfer against a built-in k-nearest-neighbor predictor
// depends on knn_pkg and the knn_graph_l2_brute_force rtl
`timescale 1ns / 100ps

module knn_graph_l2_brute_force_tb;
   import knn_pkg::*;

   typedef struct {
      logic [9:0]  query_echo;
      logic [3:0]  rank;
      logic [9:0]  neighbor;
      logic [38:0] distance;
      logic [1:0]  status;
      logic        last;
   } nbr_result_t;

   class knn_scoreboard;
      logic signed [CoordBits-1:0] coords[StoreDepth];
      int k_reg = 1;
      int n_reg = 2;
      int d_reg = 1;
      int load_ptr = 0;
      nbr_result_t pending_results[$];
      int errors = 0;
      int results_seen = 0;

      function int eff_points();
         return (n_reg > MaxPoints) ? MaxPoints : n_reg;
      endfunction

      function int eff_dims();
         if (d_reg == 0) return 1;
         return (d_reg > MaxDim) ? MaxDim : d_reg;
      endfunction

      function void write_reg(logic [1:0] idx, logic [10:0] value);
         case (idx)
            CSR_K: k_reg = value[4:0];
            CSR_POINTS: n_reg = value;
            CSR_DIMS: d_reg = value[6:0];
            default: ;
         endcase
      endfunction

      function void push_result(int q, int rank, int nb, longint unsigned dist_val,
                                logic [1:0] status, bit last);
         nbr_result_t r;
         r.query_echo = 10'(q);
         r.rank = 4'(rank);
         r.neighbor = 10'(nb);
         r.distance = 39'(dist_val);
         r.status = status;
         r.last = last;
         pending_results.push_back(r);
      endfunction

      function void note_item(bit func, logic [15:0] coord, logic [9:0] q);
         int n, d, limit, pos, x, y;
         longint unsigned best_dist[MaxK];
         int best_idx[MaxK];
         longint unsigned row_dist;
         n = eff_points();
         d = eff_dims();
         limit = n * d;
         if (func == 1'b0) begin
            if (load_ptr >= limit) load_ptr = 0;
            coords[load_ptr] = coord;
            load_ptr++;
            if (load_ptr >= limit) load_ptr = 0;
            return;
         end
         if (k_reg == 0 || k_reg > MaxK || k_reg + 1 > n) begin
            push_result(q, 0, 0, 0, STATUS_BAD_K, 1'b1);
            return;
         end
         if (q >= n) begin
            push_result(q, 0, 0, 0, STATUS_BAD_QUERY, 1'b1);
            return;
         end
         for (int j = 0; j < MaxK; j++) begin
            best_dist[j] = '1;
            best_idx[j] = 0;
         end
         for (int r = 0; r < n; r++) begin
            if (r == q) continue;
            row_dist = 0;
            for (int i = 0; i < d; i++) begin
               x = coords[q * d + i];
               y = coords[r * d + i];
               row_dist += longint'(x - y) * longint'(x - y);
            end
            if (!(row_dist < best_dist[k_reg - 1])) continue;
            pos = k_reg - 1;
            while (pos > 0 && best_dist[pos - 1] > row_dist) begin
               best_dist[pos] = best_dist[pos - 1];
               best_idx[pos] = best_idx[pos - 1];
               pos--;
            end
            best_dist[pos] = row_dist;
            best_idx[pos] = r;
         end
         for (int j = 0; j < k_reg; j++)
            push_result(q, j, best_idx[j], best_dist[j], STATUS_OK, j + 1 == k_reg);
      endfunction

      function void check_result(logic [71:0] data, logic last);
         nbr_result_t e;
         results_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response transfer data=%h last=%b", $time, data, last);
            errors++;
            return;
         end
         e = pending_results.pop_front();
         if (data[9:0] !== e.query_echo || data[13:10] !== e.rank
             || data[23:14] !== e.neighbor || data[62:24] !== e.distance
             || data[64:63] !== e.status || last !== e.last) begin
            $display("%0t: mismatch expected q=%0d rank=%0d nb=%0d dist=%0d st=%0d last=%0b",
                     $time, e.query_echo, e.rank, e.neighbor, e.distance, e.status, e.last);
            $display("%0t:          actual q=%0d rank=%0d nb=%0d dist=%0d st=%0d last=%0b",
                     $time, data[9:0], data[13:10], data[23:14], data[62:24], data[64:63],
                     last);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // coord[15:0], query[25:16]
   logic        req_tuser;   // func
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;   // query_echo, rank, neighbor, distance, status
   logic        rsp_tlast;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [10:0] csr_wdata;

   knn_scoreboard knn_sb = new();
   bit quiet = 0;
   bit hold_rsp = 0;
   int items_sent = 0;

   knn_graph_l2_brute_force dut (.*);

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   // response side: random backpressure, one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready = 1'b0;
            repeat (400) @(negedge clock);
            hold_rsp = 0;
         end else begin
            rsp_tready = quiet ? 1'b1 : ($urandom_range(99) >= 24);
         end
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) knn_sb.check_result(rsp_tdata, rsp_tlast);

   task automatic write_csr(logic [1:0] idx, logic [10:0] value);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      knn_sb.write_reg(idx, value);
   endtask

   task automatic send_item(bit func, logic [15:0] coord, logic [9:0] q);
      while (!quiet && $urandom_range(99) < 24) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = func;
      req_tdata = {6'b0, q, coord};
      do @(posedge clock); while (!req_tready);
      knn_sb.note_item(func, coord, q);
      items_sent++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic load_coord(logic [15:0] coord);
      send_item(1'b0, coord, 10'($urandom));
   endtask

   task automatic query_point(logic [9:0] q);
      send_item(1'b1, 16'($urandom), q);
   endtask

   // settle so that csr writes see an idle block
   task automatic drain();
      req_tvalid = 1'b0;
      while (knn_sb.pending_results.size() != 0) @(posedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic configure(int k, int n, int d);
      write_csr(CSR_K, 11'(k));
      write_csr(CSR_POINTS, 11'(n));
      write_csr(CSR_DIMS, 11'(d));
   endtask

   task automatic load_dataset(int count, bit ties);
      for (int i = 0; i < count; i++)
         load_coord(ties ? 16'($urandom_range(6) - 3) : 16'($urandom));
   endtask

   initial begin
      int n, d, k, phase;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_K;
      csr_wdata = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // reset settings, extreme coordinates
      load_coord(16'h7fff);
      load_coord(16'h8000);
      query_point(10'd0);
      query_point(10'd1);
      query_point(10'd2);
      query_point(10'h3ff);
      drain();

      // invalid k, large point counts without any store reads
      configure(0, 1024, 1);
      query_point(10'd5);
      drain();
      write_csr(CSR_K, 11'd17);
      query_point(10'd1023);
      drain();
      write_csr(CSR_K, 11'd31);
      write_csr(CSR_POINTS, 11'd2047);
      query_point(10'd0);
      drain();

      // wide points with extreme coordinates
      configure(1, 2, 16);
      for (int i = 0; i < 32; i++)
         load_coord(i[0] ? 16'h8000 : 16'h7fff);
      query_point(10'd0);
      query_point(10'd1);
      drain();

      // largest k with ties; receiver holds off while later queries wait
      configure(16, 17, 1);
      load_dataset(17, 1'b1);
      hold_rsp = 1;
      query_point(10'd0);
      query_point(10'd16);
      query_point(10'd8);
      query_point(10'd17);
      drain();
      write_csr(CSR_POINTS, 11'd16);
      query_point(10'd3);
      drain();

      phase = 0;
      while (items_sent < 130) begin
         quiet = (phase == 0);
         n = $urandom_range(2, 12);
         d = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
         k = ($urandom_range(7) == 0) ? $urandom_range(0, 31)
                                      : $urandom_range(1, (n - 1 < 16) ? n - 1 : 16);
         configure(k, n, d);
         load_dataset(n * ((d == 0) ? 1 : d), $urandom_range(1));
         if ($urandom_range(3) == 0) load_dataset($urandom_range(1, 3), 1'b0);
         repeat ($urandom_range(3, 7))
            query_point(($urandom_range(9) == 0) ? 10'($urandom_range(1023))
                                                 : 10'($urandom_range(n - 1)));
         drain();
         phase++;
      end
      quiet = 0;

      while (knn_sb.pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (knn_sb.errors == 0 && knn_sb.pending_results.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule

FILE: filelist.f
rtl/core/knn_pkg.sv
rtl/core/knn_ram.sv
rtl/core/knn_datapath.sv
rtl/core/knn_ctrl.sv
rtl/core/knn_graph_l2_brute_force.sv
tb/sv/knn_graph_l2_brute_force_tb.sv
